// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== src/cpo_pkg.sv =====
// Shared types and rounding helper for the capsule pair overlap test.
`timescale 1ns / 1ps
`default_nettype none
package cpo_pkg;

	typedef struct packed {
		logic signed [23:0] cx;
		logic signed [23:0] cy;
		logic signed [15:0] dx;
		logic signed [15:0] dy;
		logic        [19:0] h;
		logic        [19:0] r;
	} shape_t;

	typedef struct packed {
		logic signed [25:0] x;
		logic signed [25:0] y;
	} pt_t;

	// Q.14 product back to Q.8, halves toward plus infinity.
	function automatic logic signed [29:0] rnd14(input logic signed [43:0] p);
		logic signed [43:0] s;
		s = p + 44'sd8192;
		return s[43:14];
	endfunction

endpackage
`default_nettype wire

// ===== src/cpo_ends.sv =====
// Endpoint generation and nearer-endpoint selection, four stages.
`timescale 1ns / 1ps
`default_nettype none
module cpo_ends (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           v_i,
	input  cpo_pkg::shape_t     a_i,
	input  cpo_pkg::shape_t     b_i,
	output logic                v_o,
	output cpo_pkg::pt_t        q_o,
	output cpo_pkg::shape_t     a_o,
	output cpo_pkg::shape_t     b_o
);
	logic v_s1, v_s2, v_s3, v_s4;
	cpo_pkg::shape_t a_s1, b_s1, a_s2, b_s2, a_s3, b_s3, a_s4, b_s4;
	logic signed [36:0] pax_s1, pay_s1, pbx_s1, pby_s1;
	cpo_pkg::pt_t p1_s2, m1_s2, p2_s2, m2_s2, p1_s3, m1_s3, q_s4;
	logic signed [53:0] sq_s3 [8];

	logic signed [29:0] oax, oay, obx, oby;
	logic signed [26:0] d [8];
	logic [54:0] dpp, dpm, dmp, dmm;

	always_comb begin
		oax = cpo_pkg::rnd14(44'(pax_s1));
		oay = cpo_pkg::rnd14(44'(pay_s1));
		obx = cpo_pkg::rnd14(44'(pbx_s1));
		oby = cpo_pkg::rnd14(44'(pby_s1));
		d[0] = 27'(p1_s2.x) - 27'(p2_s2.x);
		d[1] = 27'(p1_s2.y) - 27'(p2_s2.y);
		d[2] = 27'(p1_s2.x) - 27'(m2_s2.x);
		d[3] = 27'(p1_s2.y) - 27'(m2_s2.y);
		d[4] = 27'(m1_s2.x) - 27'(p2_s2.x);
		d[5] = 27'(m1_s2.y) - 27'(p2_s2.y);
		d[6] = 27'(m1_s2.x) - 27'(m2_s2.x);
		d[7] = 27'(m1_s2.y) - 27'(m2_s2.y);
		dpp = {1'b0, sq_s3[0]} + {1'b0, sq_s3[1]};
		dpm = {1'b0, sq_s3[2]} + {1'b0, sq_s3[3]};
		dmp = {1'b0, sq_s3[4]} + {1'b0, sq_s3[5]};
		dmm = {1'b0, sq_s3[6]} + {1'b0, sq_s3[7]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_i;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= a_i;
			b_s1   <= b_i;
			pax_s1 <= a_i.dx * $signed({1'b0, a_i.h});
			pay_s1 <= a_i.dy * $signed({1'b0, a_i.h});
			pbx_s1 <= b_i.dx * $signed({1'b0, b_i.h});
			pby_s1 <= b_i.dy * $signed({1'b0, b_i.h});

			a_s2    <= a_s1;
			b_s2    <= b_s1;
			p1_s2.x <= 26'(a_s1.cx) + 26'(oax);
			p1_s2.y <= 26'(a_s1.cy) + 26'(oay);
			m1_s2.x <= 26'(a_s1.cx) - 26'(oax);
			m1_s2.y <= 26'(a_s1.cy) - 26'(oay);
			p2_s2.x <= 26'(b_s1.cx) + 26'(obx);
			p2_s2.y <= 26'(b_s1.cy) + 26'(oby);
			m2_s2.x <= 26'(b_s1.cx) - 26'(obx);
			m2_s2.y <= 26'(b_s1.cy) - 26'(oby);

			a_s3  <= a_s2;
			b_s3  <= b_s2;
			p1_s3 <= p1_s2;
			m1_s3 <= m1_s2;
			for (int i = 0; i < 8; i++) begin
				sq_s3[i] <= d[i] * d[i];
			end

			a_s4 <= a_s3;
			b_s4 <= b_s3;
			q_s4 <= (dmp < dpp || dmp < dpm || dmm < dpp || dmm < dpm) ? m1_s3 : p1_s3;
		end
	end

	assign v_o = v_s4;
	assign q_o = q_s4;
	assign a_o = a_s4;
	assign b_o = b_s4;
endmodule
`default_nettype wire

// ===== src/cpo_clamp.sv =====
// Clamp of a point onto a capsule core segment, four stages.
`timescale 1ns / 1ps
`default_nettype none
module cpo_clamp (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           v_i,
	input  cpo_pkg::shape_t     k_i,
	input  cpo_pkg::pt_t        q_i,
	input  cpo_pkg::pt_t        aux_i,
	input  cpo_pkg::shape_t     a_i,
	input  cpo_pkg::shape_t     b_i,
	output logic                v_o,
	output cpo_pkg::pt_t        o_o,
	output cpo_pkg::pt_t        aux_o,
	output cpo_pkg::shape_t     a_o,
	output cpo_pkg::shape_t     b_o
);
	logic v_s1, v_s2, v_s3, v_s4;
	cpo_pkg::shape_t k_s1, k_s2, k_s3, a_s1, a_s2, a_s3, a_s4, b_s1, b_s2, b_s3, b_s4;
	cpo_pkg::pt_t aux_s1, aux_s2, aux_s3, aux_s4, o_s4;
	logic signed [42:0] px_s1, py_s1;
	logic signed [20:0] t_s2;
	logic signed [36:0] mx_s3, my_s3;

	logic signed [26:0] ex, ey;
	logic signed [29:0] tr, hs, tc, rx, ry;

	always_comb begin
		ex = 27'(q_i.x) - 27'(k_i.cx);
		ey = 27'(q_i.y) - 27'(k_i.cy);
		tr = cpo_pkg::rnd14(44'(px_s1) + 44'(py_s1));
		hs = $signed({10'b0, k_s1.h});
		if (tr > hs)
			tc = hs;
		else if (tr < -hs)
			tc = -hs;
		else
			tc = tr;
		rx = cpo_pkg::rnd14(44'(mx_s3));
		ry = cpo_pkg::rnd14(44'(my_s3));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_i;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s1   <= k_i;
			a_s1   <= a_i;
			b_s1   <= b_i;
			aux_s1 <= aux_i;
			px_s1  <= k_i.dx * ex;
			py_s1  <= k_i.dy * ey;

			k_s2   <= k_s1;
			a_s2   <= a_s1;
			b_s2   <= b_s1;
			aux_s2 <= aux_s1;
			t_s2   <= tc[20:0];

			k_s3   <= k_s2;
			a_s3   <= a_s2;
			b_s3   <= b_s2;
			aux_s3 <= aux_s2;
			mx_s3  <= k_s2.dx * t_s2;
			my_s3  <= k_s2.dy * t_s2;

			a_s4   <= a_s3;
			b_s4   <= b_s3;
			aux_s4 <= aux_s3;
			o_s4.x <= 26'(k_s3.cx) + 26'(rx);
			o_s4.y <= 26'(k_s3.cy) + 26'(ry);
		end
	end

	assign v_o   = v_s4;
	assign o_o   = o_s4;
	assign aux_o = aux_s4;
	assign a_o   = a_s4;
	assign b_o   = b_s4;
endmodule
`default_nettype wire

// ===== src/capsule_pair_overlap_test.sv =====
// Top level of the capsule pair overlap test pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Takes one capsule pair per cycle while in_stall is low and returns one overlap flag
// per pair, in order. The pipeline is 14 register stages under one common enable:
// endpoint selection (4), clamp onto the second segment (4), clamp back onto the
// first (4) and the final distance compare (2). in_stall is high only while a result
// sits in the output register with out_stall high.
module capsule_pair_overlap_test (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [23:0] a_center_x,
	input  wire logic signed [23:0] a_center_y,
	input  wire logic signed [15:0] a_axis_x,
	input  wire logic signed [15:0] a_axis_y,
	input  wire logic        [19:0] a_half_len,
	input  wire logic        [19:0] a_radius,
	input  wire logic signed [23:0] b_center_x,
	input  wire logic signed [23:0] b_center_y,
	input  wire logic signed [15:0] b_axis_x,
	input  wire logic signed [15:0] b_axis_y,
	input  wire logic        [19:0] b_half_len,
	input  wire logic        [19:0] b_radius,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    overlap
);
	logic en;
	cpo_pkg::shape_t a_in, b_in, a_e, b_e, a_c1, b_c1, a_c2, b_c2;
	cpo_pkg::pt_t q_e, q2_c1, aux_c1, q1_c2, q2_c2;
	logic v_e, v_c1, v_c2, v_s1, v_s2;
	logic signed [53:0] sqx_s1, sqy_s1;
	logic [41:0] rs2_s1;
	logic signed [26:0] fx, fy;
	logic [20:0] rs;

	assign en       = !(v_s2 && out_stall);
	assign in_stall = !en;

	assign a_in = '{a_center_x, a_center_y, a_axis_x, a_axis_y, a_half_len, a_radius};
	assign b_in = '{b_center_x, b_center_y, b_axis_x, b_axis_y, b_half_len, b_radius};

	cpo_ends u_ends (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(in_valid), .a_i(a_in), .b_i(b_in),
		.v_o(v_e), .q_o(q_e), .a_o(a_e), .b_o(b_e)
	);

	cpo_clamp u_clamp_b (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(v_e), .k_i(b_e), .q_i(q_e),
		.aux_i(q_e), .a_i(a_e), .b_i(b_e),
		.v_o(v_c1), .o_o(q2_c1), .aux_o(aux_c1), .a_o(a_c1), .b_o(b_c1)
	);

	cpo_clamp u_clamp_a (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(v_c1), .k_i(a_c1), .q_i(q2_c1),
		.aux_i(q2_c1), .a_i(a_c1), .b_i(b_c1),
		.v_o(v_c2), .o_o(q1_c2), .aux_o(q2_c2), .a_o(a_c2), .b_o(b_c2)
	);

	always_comb begin
		fx = 27'(q1_c2.x) - 27'(q2_c2.x);
		fy = 27'(q1_c2.y) - 27'(q2_c2.y);
		rs = {1'b0, a_c2.r} + {1'b0, b_c2.r};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_c2;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s1  <= fx * fx;
			sqy_s1  <= fy * fy;
			rs2_s1  <= rs * rs;
			overlap <= ({1'b0, sqx_s1} + {1'b0, sqy_s1}) <= 55'(rs2_s1);
		end
	end

	assign out_valid = v_s2;
endmodule
`default_nettype wire

// ===== src/cpo_checker.sv =====
// Port-level checker for the capsule pair overlap test, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module cpo_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic overlap
);
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`ASSERT_NEXT(a_flag_hold, clk, arst_n, out_valid && out_stall, $stable(overlap))
	`ASSERT_IMPL(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)
	`ASSERT_IMPL(a_no_idle_stall, clk, arst_n, !out_valid || !out_stall, !in_stall)
endmodule

bind capsule_pair_overlap_test cpo_checker u_cpo_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .overlap(overlap)
);
`default_nettype wire

// ===== test/capsule_pair_overlap_test_tb.sv =====
// Self-checking testbench for the capsule pair overlap test pipeline.
`timescale 1ns / 1ps
`default_nettype none
module capsule_pair_overlap_test_tb;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 30;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic out_valid;
	logic out_stall = 1'b0;
	logic overlap;
	logic signed [23:0] a_center_x = '0, a_center_y = '0, b_center_x = '0, b_center_y = '0;
	logic signed [15:0] a_axis_x = '0, a_axis_y = '0, b_axis_x = '0, b_axis_y = '0;
	logic [19:0] a_half_len = '0, a_radius = '0, b_half_len = '0, b_radius = '0;

	bit expected_overlap[$];
	int errors = 0;
	int cycles = 0;
	int hold_request = 0;
	bit quiet_receiver = 1'b0;

	capsule_pair_overlap_test uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.a_center_x(a_center_x), .a_center_y(a_center_y),
		.a_axis_x(a_axis_x), .a_axis_y(a_axis_y),
		.a_half_len(a_half_len), .a_radius(a_radius),
		.b_center_x(b_center_x), .b_center_y(b_center_y),
		.b_axis_x(b_axis_x), .b_axis_y(b_axis_y),
		.b_half_len(b_half_len), .b_radius(b_radius),
		.out_valid(out_valid), .out_stall(out_stall), .overlap(overlap)
	);

	always #5 clk = ~clk;

	typedef struct {
		longint x;
		longint y;
	} point_t;

	// Q.14 product back to Q.8, halves toward plus infinity
	function automatic longint to_q8(longint p);
		return (p + 64'sd8192) >>> 14;
	endfunction

	function automatic longint sq_dist(point_t p, point_t q);
		return (p.x - q.x) * (p.x - q.x) + (p.y - q.y) * (p.y - q.y);
	endfunction

	function automatic point_t clamp_onto(cpo_pkg::shape_t s, point_t q);
		longint t, h;
		point_t o;
		h = longint'(s.h);
		t = to_q8(longint'(s.dx) * (q.x - longint'(s.cx)) + longint'(s.dy) * (q.y - longint'(s.cy)));
		if (t > h)
			t = h;
		if (t < -h)
			t = -h;
		o.x = longint'(s.cx) + to_q8(longint'(s.dx) * t);
		o.y = longint'(s.cy) + to_q8(longint'(s.dy) * t);
		return o;
	endfunction

	function automatic bit predict_overlap(cpo_pkg::shape_t a, cpo_pkg::shape_t b);
		point_t pa, ma, pb, mb, qa, qb;
		longint ox, oy, rs, dpp, dpm, dmp, dmm;
		ox = to_q8(longint'(a.dx) * longint'(a.h));
		oy = to_q8(longint'(a.dy) * longint'(a.h));
		pa.x = longint'(a.cx) + ox; pa.y = longint'(a.cy) + oy;
		ma.x = longint'(a.cx) - ox; ma.y = longint'(a.cy) - oy;
		ox = to_q8(longint'(b.dx) * longint'(b.h));
		oy = to_q8(longint'(b.dy) * longint'(b.h));
		pb.x = longint'(b.cx) + ox; pb.y = longint'(b.cy) + oy;
		mb.x = longint'(b.cx) - ox; mb.y = longint'(b.cy) - oy;
		dpp = sq_dist(pa, pb);
		dpm = sq_dist(pa, mb);
		dmp = sq_dist(ma, pb);
		dmm = sq_dist(ma, mb);
		qa = (dmp < dpp || dmp < dpm || dmm < dpp || dmm < dpm) ? ma : pa;
		qb = clamp_onto(b, qa);
		qa = clamp_onto(a, qb);
		rs = longint'(a.r) + longint'(b.r);
		return sq_dist(qa, qb) <= rs * rs;
	endfunction

	task automatic report_mismatch(string msg);
		$display("ERROR at cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	// mostly back to back, sometimes short gaps, rarely long ones
	function automatic int random_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 60)
			return 0;
		if (sel < 95)
			return $urandom_range(1, 4);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_pair(cpo_pkg::shape_t a, cpo_pkg::shape_t b, int gap);
		a_center_x <= a.cx; a_center_y <= a.cy; a_axis_x <= a.dx; a_axis_y <= a.dy;
		a_half_len <= a.h; a_radius <= a.r;
		b_center_x <= b.cx; b_center_y <= b.cy; b_axis_x <= b.dx; b_axis_y <= b.dy;
		b_half_len <= b.h; b_radius <= b.r;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		expected_overlap.push_back(predict_overlap(a, b));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (expected_overlap.size() == 0)
				report_mismatch("result beat with nothing expected");
			else begin
				bit want;
				want = expected_overlap.pop_front();
				if (overlap !== want)
					report_mismatch($sformatf("overlap %b, expected %b", overlap, want));
			end
		end
	end

	// receiver stalls: random runs, a quiet mode, and long holds on request
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (hold_request > 0) begin
			out_stall <= 1'b1;
			stall_left = hold_request - 1;
			hold_request = 0;
		end else if (quiet_receiver || $urandom_range(0, 99) < 70)
			out_stall <= 1'b0;
		else begin
			out_stall <= 1'b1;
			stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 50)
				: $urandom_range(0, 3);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic cpo_pkg::shape_t make_shape(longint cx, longint cy, longint dx,
		longint dy, longint h, longint r);
		cpo_pkg::shape_t s;
		s.cx = 24'(cx); s.cy = 24'(cy); s.dx = 16'(dx); s.dy = 16'(dy);
		s.h = 20'(h); s.r = 20'(r);
		return s;
	endfunction

	function automatic cpo_pkg::shape_t random_shape(int spread);
		cpo_pkg::shape_t s;
		logic [127:0] raw;
		real ang;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 8) begin
			raw = {$urandom, $urandom, $urandom, $urandom};
			return raw[119:0];
		end
		s.cx = 24'($signed($urandom_range(0, 2 * spread)) - spread);
		s.cy = 24'($signed($urandom_range(0, 2 * spread)) - spread);
		if (sel < 85) begin
			ang = $urandom_range(0, 62831) / 10000.0;
			s.dx = 16'($rtoi($cos(ang) * 16384.0));
			s.dy = 16'($rtoi($sin(ang) * 16384.0));
		end else if (sel < 92) begin
			s.dx = 16'($urandom);
			s.dy = 16'($urandom);
		end else begin
			s.dx = '0;
			s.dy = '0;
		end
		s.h = ($urandom_range(0, 4) == 0) ? 20'd0 : 20'($urandom_range(0, spread / 2));
		s.r = 20'($urandom_range(0, spread / 3));
		return s;
	endfunction

	task automatic test_directed();
		cpo_pkg::shape_t c;
		c = make_shape(0, 0, 16384, 0, 0, 256);
		send_pair(c, make_shape(512, 0, 16384, 0, 0, 256), 0);
		send_pair(c, make_shape(513, 0, 16384, 0, 0, 256), 0);
		send_pair(c, make_shape(1000, 300, 0, 16384, 2560, 100), 1);
		send_pair(make_shape(0, 0, 16384, 0, 2560, 128), make_shape(0, 256, 0, 16384, 2560, 128), 0);
		send_pair(make_shape(0, 0, 16384, 0, 2560, 128), make_shape(0, 900, 0, 16384, 512, 128), 0);
		send_pair(make_shape(-8388608, -8388608, -16384, -16384, 0, 0),
			make_shape(8388607, 8388607, 16384, 16384, 0, 0), 0);
		send_pair(make_shape(-8388608, 8388607, 16384, -16384, 1048575, 1048575),
			make_shape(8388607, -8388608, -16384, 16384, 1048575, 1048575), 2);
		send_pair(make_shape(100, 100, 0, 0, 1048575, 0), make_shape(100, 100, 0, 0, 0, 0), 0);
		send_pair(make_shape(0, 0, -32768, -32768, 1048575, 1048575),
			make_shape(0, 0, 32767, 32767, 1048575, 1048575), 0);
		send_pair(make_shape(0, 0, -32768, 32767, 4096, 10),
			make_shape(3000, -2000, 11585, 11585, 4096, 10), 0);
		send_pair(make_shape(8388607, 8388607, 0, 0, 0, 1048575),
			make_shape(-8388608, -8388608, 0, 0, 0, 1048575), 0);
		send_pair(make_shape(0, 0, 16384, 0, 1024, 0), make_shape(1024, 0, -16384, 0, 1024, 0), 0);
		send_pair(make_shape(0, 0, 16384, 0, 1024, 0), make_shape(2049, 0, 16384, 0, 1024, 0), 3);
	endtask

	task automatic test_random(int count);
		int spread;
		repeat (count) begin
			spread = ($urandom_range(0, 9) == 0) ? 1000000 : 20000;
			send_pair(random_shape(spread), random_shape(spread), random_gap());
		end
	endtask

	task automatic test_back_pressure();
		hold_request = 300;
		repeat (60) send_pair(random_shape(20000), random_shape(20000), 0);
	endtask

	task automatic test_pause_until_drained();
		in_valid <= 1'b0;
		while (expected_overlap.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic test_streaming();
		quiet_receiver = 1'b1;
		repeat (150) send_pair(random_shape(20000), random_shape(20000), 0);
		quiet_receiver = 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(500);
		test_back_pressure();
		test_pause_until_drained();
		test_streaming();
		test_random(630);
		in_valid <= 1'b0;
		while (expected_overlap.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire

// ===== capsule_pair_overlap_test.f =====
+incdir+src
src/cpo_pkg.sv
src/cpo_ends.sv
src/cpo_clamp.sv
src/capsule_pair_overlap_test.sv
src/cpo_checker.sv
test/capsule_pair_overlap_test_tb.sv
